// ===== hw/rtl/acpu_pkg.sv =====
`default_nettype none

package acpu_pkg;

  // Width of the internal access and instruction counters
  localparam int unsigned CountWidth = 32;
  // Width of the counters as reported on the result
  localparam int unsigned ResCountWidth = 32;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_EXEC    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RUN_GO   = 2'd0,
    RUN_HALT = 2'd1,
    RUN_BAD  = 2'd2
  } run_e;

  localparam logic [7:0] OpNop = 8'h00;
  localparam logic [7:0] OpSta = 8'h10;
  localparam logic [7:0] OpLda = 8'h20;
  localparam logic [7:0] OpAdd = 8'h30;
  localparam logic [7:0] OpOr  = 8'h40;
  localparam logic [7:0] OpAnd = 8'h50;
  localparam logic [7:0] OpNot = 8'h70;
  localparam logic [7:0] OpJmp = 8'h80;
  localparam logic [7:0] OpJn  = 8'h90;
  localparam logic [7:0] OpJz  = 8'hA0;
  localparam logic [7:0] OpHlt = 8'hF0;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] address;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0]               accumulator;
    logic [7:0]               program_counter;
    logic [7:0]               instruction_byte;
    logic                     negative_flag;
    logic                     zero_flag;
    logic [1:0]               run_status;
    logic [7:0]               read_value;
    logic [ResCountWidth-1:0] access_count;
    logic [ResCountWidth-1:0] instruction_count;
  } result_t;

  typedef enum logic [1:0] {
    ADDR_ITEM,
    ADDR_PC,
    ADDR_PC_NEXT,
    ADDR_OPND
  } addr_sel_e;

  typedef enum logic [2:0] {
    PC_HOLD,
    PC_INC1,
    PC_INC2,
    PC_JUMP,
    PC_START
  } pc_op_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_NOT,
    ACC_LOAD,
    ACC_ADD,
    ACC_OR,
    ACC_AND
  } acc_op_e;

  // Controller to datapath
  typedef struct packed {
    logic      latch_item;
    logic      mem_rd;
    logic      mem_wr;
    addr_sel_e addr_sel;
    logic      wr_acc;
    logic      capture_read;
    logic      restart;
    logic      fetch;
    logic      decode;
    pc_op_e    pc_op;
    acc_op_e   acc_op;
    logic [1:0] access_add;
    logic      set_halt;
    logic      set_bad;
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic [7:0] rdata;
    logic [7:0] ir;
    run_e       run;
    logic       neg;
    logic       zer;
  } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/acpu_dpath.sv =====
`default_nettype none

module acpu_dpath import acpu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  item_t      item_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  input  ctrl_t      ctrl_i,
  output stat_t      stat_o,
  output result_t    res_o
);

  item_t                 item_q;
  logic [7:0]            start_q;
  logic [7:0]            acc_q, acc_d;
  logic [7:0]            pc_q, pc_d;
  logic [7:0]            ir_q;
  logic                  neg_q, zer_q;
  run_e                  run_q;
  logic [CountWidth-1:0] acnt_q, icnt_q;
  logic [7:0]            rdval_q;

  logic [7:0]            mem [256];
  logic [255:0]          vld_q;
  logic [7:0]            mem_q;
  logic                  mvld_q;
  logic [7:0]            rdata;
  logic [7:0]            addr;
  logic [7:0]            wdata;

  // Entries never written read as zero
  assign rdata = mvld_q ? mem_q : 8'h00;
  assign wdata = ctrl_i.wr_acc ? acc_q : item_q.data;

  always_comb begin
    unique case (ctrl_i.addr_sel)
      ADDR_ITEM:    addr = item_q.address;
      ADDR_PC:      addr = pc_q;
      ADDR_PC_NEXT: addr = pc_q + 8'd1;
      ADDR_OPND:    addr = rdata;
      default:      addr = item_q.address;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mem_wr) begin
      mem[addr] <= wdata;
    end
    if (ctrl_i.mem_rd) begin
      mem_q <= mem[addr];
    end
    if (ctrl_i.latch_item) begin
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      mvld_q <= 1'b0;
    end else begin
      if (ctrl_i.mem_wr) begin
        vld_q[addr] <= 1'b1;
      end
      if (ctrl_i.mem_rd) begin
        mvld_q <= vld_q[addr];
      end
    end
  end

  always_comb begin
    unique case (ctrl_i.acc_op)
      ACC_HOLD: acc_d = acc_q;
      ACC_NOT:  acc_d = ~acc_q;
      ACC_LOAD: acc_d = rdata;
      ACC_ADD:  acc_d = acc_q + rdata;
      ACC_OR:   acc_d = acc_q | rdata;
      ACC_AND:  acc_d = acc_q & rdata;
      default:  acc_d = acc_q;
    endcase
  end

  always_comb begin
    unique case (ctrl_i.pc_op)
      PC_HOLD:  pc_d = pc_q;
      PC_INC1:  pc_d = pc_q + 8'd1;
      PC_INC2:  pc_d = pc_q + 8'd2;
      PC_JUMP:  pc_d = rdata;
      PC_START: pc_d = start_q;
      default:  pc_d = pc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 8'h00;
      acc_q   <= 8'h00;
      pc_q    <= 8'h00;
      ir_q    <= 8'h00;
      neg_q   <= 1'b0;
      zer_q   <= 1'b1;
      run_q   <= RUN_GO;
      acnt_q  <= '0;
      icnt_q  <= '0;
      rdval_q <= 8'h00;
    end else begin
      if (cfg_we_i) begin
        start_q <= cfg_data_i;
      end
      if (ctrl_i.latch_item) begin
        rdval_q <= 8'h00;
      end else if (ctrl_i.capture_read) begin
        rdval_q <= rdata;
      end
      pc_q <= pc_d;
      if (ctrl_i.restart) begin
        acc_q  <= 8'h00;
        ir_q   <= 8'h00;
        neg_q  <= 1'b0;
        zer_q  <= 1'b1;
        run_q  <= RUN_GO;
        acnt_q <= '0;
        icnt_q <= '0;
      end else begin
        if (ctrl_i.acc_op != ACC_HOLD) begin
          acc_q <= acc_d;
          neg_q <= acc_d[7];
          zer_q <= (acc_d == 8'h00);
        end
        if (ctrl_i.decode) begin
          ir_q <= rdata;
        end
        if (ctrl_i.set_halt) begin
          run_q <= RUN_HALT;
        end else if (ctrl_i.set_bad) begin
          run_q <= RUN_BAD;
        end
        acnt_q <= acnt_q + CountWidth'(ctrl_i.access_add);
        if (ctrl_i.fetch) begin
          icnt_q <= icnt_q + CountWidth'(1);
        end
      end
    end
  end

  assign stat_o.rdata = rdata;
  assign stat_o.ir    = ir_q;
  assign stat_o.run   = run_q;
  assign stat_o.neg   = neg_q;
  assign stat_o.zer   = zer_q;

  assign res_o.accumulator       = acc_q;
  assign res_o.program_counter   = pc_q;
  assign res_o.instruction_byte  = ir_q;
  assign res_o.negative_flag     = neg_q;
  assign res_o.zero_flag         = zer_q;
  assign res_o.run_status        = run_q;
  assign res_o.read_value        = rdval_q;
  assign res_o.access_count      = ResCountWidth'(acnt_q);
  assign res_o.instruction_count = ResCountWidth'(icnt_q);

endmodule

`default_nettype wire

// ===== hw/rtl/acpu_ctrl.sv =====
`default_nettype none

module acpu_ctrl import acpu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] command_i,
  input  stat_t      stat_i,
  output logic       busy_o,
  output logic       done_o,
  output ctrl_t      ctrl_o
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_WR     = 10'b00_0000_0010,
    S_RD     = 10'b00_0000_0100,
    S_RDW    = 10'b00_0000_1000,
    S_RST    = 10'b00_0001_0000,
    S_FETCH  = 10'b00_0010_0000,
    S_DECODE = 10'b00_0100_0000,
    S_OPND   = 10'b00_1000_0000,
    S_EXEC   = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctrl_o.latch_item = 1'b1;
          unique case (cmd_e'(command_i))
            CMD_WRITE:   state_d = S_WR;
            CMD_READ:    state_d = S_RD;
            CMD_EXEC:    state_d = (stat_i.run == RUN_GO) ? S_FETCH : S_DONE;
            CMD_RESTART: state_d = S_RST;
            default:     state_d = S_DONE;
          endcase
        end
      end
      S_WR: begin
        ctrl_o.mem_wr   = 1'b1;
        ctrl_o.addr_sel = ADDR_ITEM;
        state_d         = S_DONE;
      end
      S_RD: begin
        ctrl_o.mem_rd   = 1'b1;
        ctrl_o.addr_sel = ADDR_ITEM;
        state_d         = S_RDW;
      end
      S_RDW: begin
        ctrl_o.capture_read = 1'b1;
        state_d             = S_DONE;
      end
      S_RST: begin
        ctrl_o.restart = 1'b1;
        ctrl_o.pc_op   = PC_START;
        state_d        = S_DONE;
      end
      S_FETCH: begin
        ctrl_o.mem_rd     = 1'b1;
        ctrl_o.addr_sel   = ADDR_PC;
        ctrl_o.fetch      = 1'b1;
        ctrl_o.access_add = 2'd1;
        state_d           = S_DECODE;
      end
      S_DECODE: begin
        // Prefetch the operand byte whatever the opcode turns out to be
        ctrl_o.decode   = 1'b1;
        ctrl_o.mem_rd   = 1'b1;
        ctrl_o.addr_sel = ADDR_PC_NEXT;
        state_d         = S_DONE;
        unique case (stat_i.rdata)
          OpNop: ctrl_o.pc_op = PC_INC1;
          OpNot: begin
            ctrl_o.acc_op = ACC_NOT;
            ctrl_o.pc_op  = PC_INC1;
          end
          OpHlt: begin
            ctrl_o.pc_op    = PC_INC1;
            ctrl_o.set_halt = 1'b1;
          end
          OpSta, OpLda, OpAdd, OpOr, OpAnd, OpJmp, OpJn, OpJz: state_d = S_OPND;
          default: ctrl_o.set_bad = 1'b1;
        endcase
      end
      S_OPND: begin
        ctrl_o.access_add = 2'd1;
        ctrl_o.addr_sel   = ADDR_OPND;
        state_d           = S_DONE;
        unique case (stat_i.ir)
          OpSta: begin
            ctrl_o.mem_wr     = 1'b1;
            ctrl_o.wr_acc     = 1'b1;
            ctrl_o.access_add = 2'd2;
            ctrl_o.pc_op      = PC_INC2;
          end
          OpLda, OpAdd, OpOr, OpAnd: begin
            ctrl_o.mem_rd = 1'b1;
            state_d       = S_EXEC;
          end
          OpJmp:   ctrl_o.pc_op = PC_JUMP;
          OpJn:    ctrl_o.pc_op = stat_i.neg ? PC_JUMP : PC_INC2;
          OpJz:    ctrl_o.pc_op = stat_i.zer ? PC_JUMP : PC_INC2;
          default: ctrl_o.pc_op = PC_HOLD;
        endcase
      end
      S_EXEC: begin
        ctrl_o.access_add = 2'd1;
        ctrl_o.pc_op      = PC_INC2;
        state_d           = S_DONE;
        unique case (stat_i.ir)
          OpLda:   ctrl_o.acc_op = ACC_LOAD;
          OpAdd:   ctrl_o.acc_op = ACC_ADD;
          OpOr:    ctrl_o.acc_op = ACC_OR;
          OpAnd:   ctrl_o.acc_op = ACC_AND;
          default: ctrl_o.acc_op = ACC_HOLD;
        endcase
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/accumulator_cpu_8bit_core.sv =====
`default_nettype none

// 8-bit accumulator processor with a 256-byte single-port memory that reads
// as all zero after reset (per-byte valid flops, so no clearing pass is
// needed). Issue an item by raising start while busy is low; one result
// comes back on res_o for exactly one cycle, marked by done_o, and the
// receiver cannot stall it, so capture it on that cycle. After done_o the
// core returns to idle before it takes the next item. States before DONE:
// write WR, read RD and RDW, restart RST, execute while stopped none,
// NOP/NOT/HLT/invalid opcode FETCH and DECODE, STA/JMP/JN/JZ also OPND,
// and LDA/ADD/OR/AND also OPND and EXEC. The one memory port has a
// registered read, so opcode fetch, operand address fetch and operand
// access each take their own state. The start address register may be
// written on the cfg channel at any time the core is idle; cfg_ready_o stays high.
module accumulator_cpu_8bit_core import acpu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Command channel
  input  logic       start,
  output logic       busy,
  input  item_t      item_i,
  // Result strobe
  output logic       done_o,
  output result_t    res_o,
  // Start address register
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  ctrl_t ctrl;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  // Sequence each command through the memory port
  acpu_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .command_i (item_i.command),
    .stat_i    (stat),
    .busy_o    (busy),
    .done_o    (done_o),
    .ctrl_o    (ctrl)
  );

  // Hold the architectural state, memory and counters
  acpu_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .res_o      (res_o)
  );

endmodule

`default_nettype wire
